[rtl/assert_macros.svh]
// Assertion macros for the RTL files that carry checks (the top level).
// No dependencies; clock and reset are passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SMF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define SMF_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/smf_pkg.sv]
// Shared constants, codes and controller/datapath structs for the
// Simpson velocity moment block. No dependencies.
package smf_pkg;

  localparam int SMF_MAX_AXIS_POINTS = 256;
  localparam int SMF_MAX_ROWS        = 16;
  localparam int NUM_MOMENTS         = 5;
  localparam int SAMPLE_W            = 32;
  localparam int VEL_W               = 16;
  localparam int SUM_W               = 64;
  localparam int ROW_IDX_W           = 4;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 32;
  localparam int K_W                 = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINTS_X     = 3'd0,
    CFG_POINTS_Y     = 3'd1,
    CFG_POINTS_Z     = 3'd2,
    CFG_VOLUME_SCALE = 3'd3,
    CFG_ROW_COUNT    = 3'd4
  } cfg_idx_t;

  // operand pair for the shared multiplier
  typedef enum logic [3:0] {
    MS_NONE, MS_VXX, MS_VYY, MS_VZZ, MS_SVX, MS_SVY, MS_SVZ, MS_SV2, MS_LO, MS_HI
  } mul_sel_t;

  // what the datapath does with the registered product / accumulators
  typedef enum logic [3:0] {
    PA_NONE, PA_DENS, PA_V2SET, PA_V2ADD, PA_ACCX, PA_ACCY, PA_ACCZ, PA_ACCE,
    PA_MAG, PA_PLO, PA_SUM, PA_OUT
  } post_t;

  typedef struct packed {
    logic           load;
    mul_sel_t       mul_sel;
    post_t          post;
    logic           step;
    logic           emit;
    logic [K_W-1:0] k;
  } smf_cmd_t;

  typedef struct packed {
    logic row_end;
    logic out_busy;
  } smf_sts_t;

endpackage

[rtl/smf_if.sv]
// Valid/ready channel interfaces: grid sample input, moment result
// output and configuration write. Depend on smf_pkg.
interface smf_in_if import smf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [VEL_W-1:0]    vel_x;
  logic signed [VEL_W-1:0]    vel_y;
  logic signed [VEL_W-1:0]    vel_z;
  modport source (output valid, sample, vel_x, vel_y, vel_z, input ready);
  modport sink   (input valid, sample, vel_x, vel_y, vel_z, output ready);
endinterface

interface smf_out_if import smf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] density_sum;
  logic signed [SUM_W-1:0] momentum_x;
  logic signed [SUM_W-1:0] momentum_y;
  logic signed [SUM_W-1:0] momentum_z;
  logic signed [SUM_W-1:0] energy_sum;
  logic [ROW_IDX_W-1:0]    row_index;
  modport source (output valid, density_sum, momentum_x, momentum_y, momentum_z,
                  energy_sum, row_index, input ready);
  modport sink   (input valid, density_sum, momentum_x, momentum_y, momentum_z,
                  energy_sum, row_index, output ready);
endinterface

interface smf_cfg_if import smf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/smf_ctrl.sv]
// Sequencer for the moment datapath: issues multiplier and update
// commands per grid sample and the row-end scaling pass. Uses smf_pkg.
module smf_ctrl import smf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  smf_sts_t sts,
  output smf_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_MX, S_MY, S_MZ, S_ME, S_FIN,
    S_SC_MAG, S_SC_LO, S_SC_HI, S_SC_SUM, S_SC_OUT, S_EMIT
  } state_t;

  state_t         state_r, state_nxt;
  logic [K_W-1:0] k_r, k_nxt;

  // command decode and next state
  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = MS_NONE;
    cmd.post    = PA_NONE;
    cmd.k       = k_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.mul_sel = MS_VXX; cmd.post = PA_DENS;  state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.mul_sel = MS_VYY; cmd.post = PA_V2SET; state_nxt = S_SQZ;
      end
      S_SQZ: begin
        cmd.mul_sel = MS_VZZ; cmd.post = PA_V2ADD; state_nxt = S_MX;
      end
      S_MX: begin
        cmd.mul_sel = MS_SVX; cmd.post = PA_V2ADD; state_nxt = S_MY;
      end
      S_MY: begin
        cmd.mul_sel = MS_SVY; cmd.post = PA_ACCX;  state_nxt = S_MZ;
      end
      S_MZ: begin
        cmd.mul_sel = MS_SVZ; cmd.post = PA_ACCY;  state_nxt = S_ME;
      end
      S_ME: begin
        cmd.mul_sel = MS_SV2; cmd.post = PA_ACCZ;  state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.post = PA_ACCE;
        cmd.step = 1'b1;
        if (sts.row_end) begin
          k_nxt     = '0;
          state_nxt = S_SC_MAG;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SC_MAG: begin
        cmd.post = PA_MAG; state_nxt = S_SC_LO;
      end
      S_SC_LO: begin
        cmd.mul_sel = MS_LO; state_nxt = S_SC_HI;
      end
      S_SC_HI: begin
        cmd.mul_sel = MS_HI; cmd.post = PA_PLO; state_nxt = S_SC_SUM;
      end
      S_SC_SUM: begin
        cmd.post = PA_SUM; state_nxt = S_SC_OUT;
      end
      S_SC_OUT: begin
        cmd.post = PA_OUT;
        if (k_r == K_W'(NUM_MOMENTS - 1)) begin
          state_nxt = S_EMIT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_SC_MAG;
        end
      end
      S_EMIT: begin
        // wait for the output register to drain
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and scaling index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

[rtl/smf_dp.sv]
// Moment datapath: config registers, axis and row counters, shared
// multiplier, saturating accumulators, scaling and output register. Uses smf_pkg.
module smf_dp import smf_pkg::*; #(
  parameter int MAX_AXIS_POINTS = SMF_MAX_AXIS_POINTS,
  parameter int MAX_ROWS        = SMF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smf_cmd_t              cmd,
  output smf_sts_t              sts,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic [VEL_W-1:0]      in_vel_x,
  input  logic [VEL_W-1:0]      in_vel_y,
  input  logic [VEL_W-1:0]      in_vel_z,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [SUM_W-1:0]      out_density_sum,
  output logic [SUM_W-1:0]      out_momentum_x,
  output logic [SUM_W-1:0]      out_momentum_y,
  output logic [SUM_W-1:0]      out_momentum_z,
  output logic [SUM_W-1:0]      out_energy_sum,
  output logic [ROW_IDX_W-1:0]  out_row_index
);

  localparam int IW = $clog2(MAX_AXIS_POINTS);
  localparam int NW = IW + 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

  // clamp a grid size to 2..MAX_AXIS_POINTS
  function automatic logic [NW-1:0] clamp_pts(input logic [8:0] p);
    logic [NW-1:0] r;
    if (p < 9'd2)                       r = NW'(2);
    else if (32'(p) > MAX_AXIS_POINTS)  r = NW'(MAX_AXIS_POINTS);
    else                                r = NW'(p);
    return r;
  endfunction

  // log2 of the Simpson weight: end points 1, odd 4, even 2
  function automatic logic [1:0] wexp(input logic [IW-1:0] i, input logic [NW-1:0] n);
    logic [1:0] r;
    if (i == '0 || {1'b0, i} >= n - 1'b1) r = 2'd0;
    else if (i[0])                          r = 2'd2;
    else                                    r = 2'd1;
    return r;
  endfunction

  // configuration registers
  logic [8:0]  pts_x_r, pts_y_r, pts_z_r;
  logic [31:0] scale_r;
  logic [4:0]  row_count_r;

  // counters
  logic [IW-1:0] idx_x_r, idx_y_r, idx_z_r;
  logic [RW-1:0] row_r;

  // item operands
  logic [SAMPLE_W-1:0] s_r;
  logic [VEL_W-1:0]    vx_r, vy_r, vz_r;
  logic [2:0]          wsh_r;
  logic [31:0]         v2_r;

  // multiplier and scaling
  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;
  logic [65:0]        prod_r;
  logic [63:0]        mag_r, plo_r, q_r;
  logic               neg_r, big_r, rem_r;
  logic [SUM_W-1:0]   acc_r [NUM_MOMENTS];
  logic [SUM_W-1:0]   res_r [NUM_MOMENTS];

  logic [NW-1:0] nx, ny, nz;
  logic          lx, ly, lz;
  logic [RW:0]   nr, row_inc;

  logic [K_W-1:0]   rd_idx;
  logic             acc_upd;
  logic [SUM_W-1:0] acc_rd, term, shifted, sum, sat;
  logic             ovf;
  logic [64:0]      qsum;
  logic [SUM_W-1:0] res_val;

  assign nx = clamp_pts(pts_x_r);
  assign ny = clamp_pts(pts_y_r);
  assign nz = clamp_pts(pts_z_r);
  assign lx = {1'b0, idx_x_r} >= nx - 1'b1;
  assign ly = {1'b0, idx_y_r} >= ny - 1'b1;
  assign lz = {1'b0, idx_z_r} >= nz - 1'b1;

  // row count clamped to 1..MAX_ROWS
  always_comb begin
    if (row_count_r == 5'd0)             nr = (RW+1)'(1);
    else if (32'(row_count_r) > MAX_ROWS) nr = (RW+1)'(MAX_ROWS);
    else                                  nr = (RW+1)'(row_count_r);
    row_inc = {1'b0, row_r} + 1'b1;
  end

  assign sts.row_end  = lx & ly & lz;
  assign sts.out_busy = out_valid;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_x_r     <= 9'd3;
      pts_y_r     <= 9'd3;
      pts_z_r     <= 9'd3;
      scale_r     <= 32'h0001_0000;
      row_count_r <= 5'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POINTS_X:     pts_x_r     <= cfg_data[8:0];
        CFG_POINTS_Y:     pts_y_r     <= cfg_data[8:0];
        CFG_POINTS_Z:     pts_z_r     <= cfg_data[8:0];
        CFG_VOLUME_SCALE: scale_r     <= cfg_data;
        CFG_ROW_COUNT:    row_count_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // axis and row counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_x_r <= '0;
      idx_y_r <= '0;
      idx_z_r <= '0;
      row_r   <= '0;
    end else begin
      if (cmd.step) begin
        if (!lz) idx_z_r <= idx_z_r + 1'b1;
        else begin
          idx_z_r <= '0;
          if (!ly) idx_y_r <= idx_y_r + 1'b1;
          else begin
            idx_y_r <= '0;
            if (!lx) idx_x_r <= idx_x_r + 1'b1;
            else     idx_x_r <= '0;
          end
        end
      end
      if (cmd.emit) row_r <= (row_inc >= nr) ? '0 : row_inc[RW-1:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MS_VXX: begin op_a = 33'(signed'(vx_r)); op_b = 33'(signed'(vx_r)); end
      MS_VYY: begin op_a = 33'(signed'(vy_r)); op_b = 33'(signed'(vy_r)); end
      MS_VZZ: begin op_a = 33'(signed'(vz_r)); op_b = 33'(signed'(vz_r)); end
      MS_SVX: begin op_a = 33'(signed'(s_r));  op_b = 33'(signed'(vx_r)); end
      MS_SVY: begin op_a = 33'(signed'(s_r));  op_b = 33'(signed'(vy_r)); end
      MS_SVZ: begin op_a = 33'(signed'(s_r));  op_b = 33'(signed'(vz_r)); end
      MS_SV2: begin op_a = 33'(signed'(s_r));  op_b = signed'({1'b0, v2_r}); end
      MS_LO:  begin op_a = signed'({1'b0, mag_r[31:0]});  op_b = signed'({1'b0, scale_r}); end
      MS_HI:  begin op_a = signed'({1'b0, mag_r[63:32]}); op_b = signed'({1'b0, scale_r}); end
      default: ;
    endcase
  end
  assign prod = op_a * op_b;

  // accumulator read port and saturating update
  always_comb begin
    acc_upd = 1'b1;
    rd_idx  = cmd.k;
    term    = '0;
    case (cmd.post)
      PA_DENS: begin rd_idx = K_W'(0); term = {{32{s_r[31]}}, s_r}; end
      PA_ACCX: begin rd_idx = K_W'(1); term = {{6{prod_r[65]}}, prod_r[65:8]}; end
      PA_ACCY: begin rd_idx = K_W'(2); term = {{6{prod_r[65]}}, prod_r[65:8]}; end
      PA_ACCZ: begin rd_idx = K_W'(3); term = {{6{prod_r[65]}}, prod_r[65:8]}; end
      PA_ACCE: begin rd_idx = K_W'(4); term = {{14{prod_r[65]}}, prod_r[65:16]}; end
      default: acc_upd = 1'b0;
    endcase
    acc_rd  = acc_r[rd_idx];
    shifted = term << wsh_r;
    sum     = acc_rd + shifted;
    ovf     = (acc_rd[63] == shifted[63]) && (sum[63] != acc_rd[63]);
    sat     = ovf ? (shifted[63] ? SMIN : SMAX) : sum;
  end

  // scaled sum: floor(sum * scale / 2^16) with saturation
  always_comb begin
    qsum = {1'b0, prod_r[47:0], 16'h0000} + {17'h0, plo_r[63:16]};
    if (!neg_r) begin
      res_val = (big_r || q_r[63]) ? SMAX : q_r;
    end else if (big_r || q_r[63] || (rem_r && (&q_r[62:0]))) begin
      res_val = SMIN;
    end else begin
      res_val = rem_r ? ~q_r : (~q_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MOMENTS; i++) acc_r[i] <= '0;
    end else if (cmd.emit) begin
      for (int i = 0; i < NUM_MOMENTS; i++) acc_r[i] <= '0;
    end else if (acc_upd) begin
      acc_r[rd_idx] <= sat;
    end
  end

  // operand latch, product register and scaling stages
  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (cmd.load) begin
      s_r   <= in_sample;
      vx_r  <= in_vel_x;
      vy_r  <= in_vel_y;
      vz_r  <= in_vel_z;
      wsh_r <= 3'(wexp(idx_x_r, nx)) + 3'(wexp(idx_y_r, ny)) + 3'(wexp(idx_z_r, nz));
    end
    case (cmd.post)
      PA_V2SET: v2_r <= prod_r[31:0];
      PA_V2ADD: v2_r <= v2_r + prod_r[31:0];
      PA_MAG: begin
        neg_r <= acc_rd[63];
        mag_r <= acc_rd[63] ? (~acc_rd + 1'b1) : acc_rd;
      end
      PA_PLO: plo_r <= prod_r[63:0];
      PA_SUM: begin
        q_r   <= qsum[63:0];
        big_r <= (|prod_r[63:48]) | qsum[64];
        rem_r <= |plo_r[15:0];
      end
      PA_OUT: res_r[cmd.k] <= res_val;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_density_sum <= res_r[0];
      out_momentum_x  <= res_r[1];
      out_momentum_y  <= res_r[2];
      out_momentum_z  <= res_r[3];
      out_energy_sum  <= res_r[4];
      out_row_index   <= ROW_IDX_W'(row_r);
    end
  end

endmodule

[rtl/simpson_fluid_moments_3d.sv]
// Top level of the composite Simpson 3-D velocity moment block.
// Depends on smf_pkg, smf_if, smf_ctrl, smf_dp and assert_macros.svh.
//
// Usage:
//   in_ch  : one grid sample (Q8.24) with its velocity (Q8.8 x3) per transfer,
//            x-outer, y-middle, z-inner order.
//   out_ch : after the last point of a row, one transfer with the five scaled
//            moments (Q40.24, saturated) and the row index.
//   cfg_ch : register writes, index 0..4 = points_x, points_y, points_z,
//            volume_scale, row_count; always ready. Write only while idle.
// Sequence: a sample is accepted, then passes the steps on the one shared
//   33x33 multiplier (three squares, three momenta, the energy product) and
//   a final accumulate step; no new sample is taken until it is done. The last
//   sample of a row adds a scaling pass (per moment: magnitude, two multiplier
//   passes, sum and output) and an emit step.
// Stall: the result waits in the output register; new samples are taken
//   meanwhile, and only the next row end waits for the register to drain.
// Reset (rst_n low, synchronous): counters and sums clear, registers take
//   their defaults, no result is pending.
`include "assert_macros.svh"

module simpson_fluid_moments_3d import smf_pkg::*; #(
  parameter int MAX_AXIS_POINTS = SMF_MAX_AXIS_POINTS,
  parameter int MAX_ROWS        = SMF_MAX_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  smf_in_if.sink     in_ch,
  smf_out_if.source  out_ch,
  smf_cfg_if.sink    cfg_ch
);

  smf_cmd_t         cmd;
  smf_sts_t         sts;
  logic             in_ready;
  logic             out_valid;
  logic [SUM_W-1:0] dens, mx, my, mz, en;
  logic [ROW_IDX_W-1:0] row_idx;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  smf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smf_dp #(
    .MAX_AXIS_POINTS (MAX_AXIS_POINTS),
    .MAX_ROWS        (MAX_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample       (in_ch.sample),
    .in_vel_x        (in_ch.vel_x),
    .in_vel_y        (in_ch.vel_y),
    .in_vel_z        (in_ch.vel_z),
    .cfg_valid       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_ready       (out_ch.ready),
    .out_valid       (out_valid),
    .out_density_sum (dens),
    .out_momentum_x  (mx),
    .out_momentum_y  (my),
    .out_momentum_z  (mz),
    .out_energy_sum  (en),
    .out_row_index   (row_idx)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.density_sum = dens;
  assign out_ch.momentum_x  = mx;
  assign out_ch.momentum_y  = my;
  assign out_ch.momentum_z  = mz;
  assign out_ch.energy_sum  = en;
  assign out_ch.row_index   = row_idx;

  // checks
  `SMF_ASSERT(a_busy_after_accept, clk, rst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "sample accepted while busy")
  `SMF_NEVER(a_no_overwrite, clk, rst_n, cmd.emit && out_valid, "result overwritten")
  `SMF_ASSERT(a_emit_shows, clk, rst_n, cmd.emit |=> out_ch.valid, "emitted result not shown")
  `SMF_NEVER(a_no_load_in_emit, clk, rst_n, cmd.emit && cmd.load, "load during emit")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for simpson_fluid_moments_3d: drives grid samples,
// predicts the scaled Simpson moments per row and compares each result transfer.
// Depends on smf_pkg, smf_if and the RTL top level.
`timescale 1ns / 100ps

module tb_top;
  import smf_pkg::*;

  typedef struct packed {
    logic signed [31:0] sample;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } grid_pt_t;

  typedef struct packed {
    logic signed [63:0] dens;
    logic signed [63:0] mx;
    logic signed [63:0] my;
    logic signed [63:0] mz;
    logic signed [63:0] energy;
    logic [3:0]         row;
  } moments_t;

  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

  logic clk;
  logic rst_n;
  smf_in_if  in_ch ();
  smf_out_if out_ch ();
  smf_cfg_if cfg_ch ();

  simpson_fluid_moments_3d uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // shadow registers and grid state
  int unsigned pts_x, pts_y, pts_z, vol_scale, rows_cfg;
  int unsigned ix, iy, iz, row_ctr;
  longint      acc [5];

  grid_pt_t pending_pts[$];
  moments_t expected_rows[$];
  int       n_errors;
  bit       hold_off;
  bit       in_taken, out_taken;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned clamp_pts(int unsigned p);
    if (p < 2) return 2;
    if (p > SMF_MAX_AXIS_POINTS) return SMF_MAX_AXIS_POINTS;
    return p;
  endfunction

  function automatic int weight_log2(int unsigned i, int unsigned n);
    if (i == 0 || i >= n - 1) return 0;
    return i[0] ? 2 : 1;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(S64_MAX)) return S64_MAX;
    if (s < 65'(S64_MIN)) return S64_MIN;
    return longint'(s);
  endfunction

  // floor(a * scale / 2^16), saturated
  function automatic longint apply_volume(longint a, int unsigned scale);
    logic signed [127:0] p;
    p = (128'(a) * $signed({96'd0, scale})) >>> 16;
    if (p > 128'(S64_MAX)) return S64_MAX;
    if (p < 128'(S64_MIN)) return S64_MIN;
    return longint'(p);
  endfunction

  // accumulate one sample; pushes a row result at the end of the grid
  task automatic predict_point(grid_pt_t g);
    int unsigned nx, ny, nz, nr;
    int          sh;
    longint      s, vx, vy, vz, v2;
    longint      t [5];
    moments_t    m;
    nx = clamp_pts(pts_x); ny = clamp_pts(pts_y); nz = clamp_pts(pts_z);
    nr = rows_cfg < 1 ? 1 : (rows_cfg > SMF_MAX_ROWS ? SMF_MAX_ROWS : rows_cfg);
    sh = weight_log2(ix, nx) + weight_log2(iy, ny) + weight_log2(iz, nz);
    s = g.sample; vx = g.vx; vy = g.vy; vz = g.vz;
    v2 = vx * vx + vy * vy + vz * vz;
    t[0] = s;
    t[1] = (s * vx) >>> 8;
    t[2] = (s * vy) >>> 8;
    t[3] = (s * vz) >>> 8;
    t[4] = (s * v2) >>> 16;
    for (int k = 0; k < 5; k++) acc[k] = sat_sum(acc[k], t[k] <<< sh);
    if (iz < nz - 1) begin iz++; return; end
    iz = 0;
    if (iy < ny - 1) begin iy++; return; end
    iy = 0;
    if (ix < nx - 1) begin ix++; return; end
    ix = 0;
    m.dens   = apply_volume(acc[0], vol_scale);
    m.mx     = apply_volume(acc[1], vol_scale);
    m.my     = apply_volume(acc[2], vol_scale);
    m.mz     = apply_volume(acc[3], vol_scale);
    m.energy = apply_volume(acc[4], vol_scale);
    m.row    = row_ctr[3:0];
    for (int k = 0; k < 5; k++) acc[k] = 0;
    expected_rows.push_back(m);
    row_ctr++;
    if (row_ctr >= nr) row_ctr = 0;
  endtask

  // transfers seen at the rising edge, used by the falling-edge drivers
  always @(posedge clk) begin
    in_taken  <= rst_n && in_ch.valid && in_ch.ready;
    out_taken <= rst_n && out_ch.valid && out_ch.ready;
  end

  // sample driver: random gap per transfer, fed from pending_pts
  int gap_left;
  initial begin
    in_ch.valid = 1'b0; in_ch.sample = '0;
    in_ch.vel_x = '0; in_ch.vel_y = '0; in_ch.vel_z = '0;
    gap_left = 0;
  end
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (in_ch.valid && !in_taken) begin
        // item still waiting for its transfer: hold it
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_pts.size() > 0) begin
        grid_pt_t g;
        g = pending_pts.pop_front();
        in_ch.sample <= g.sample; in_ch.vel_x <= g.vx;
        in_ch.vel_y <= g.vy; in_ch.vel_z <= g.vz;
        in_ch.valid <= 1'b1;
        predict_point(g);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus a long hold-off when requested
  int stall_left;
  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
  end
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (hold_off) out_ch.ready <= 1'b0;
      else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected result transfer row %0d", $time, out_ch.row_index);
        n_errors++;
      end else begin
        moments_t e;
        e = expected_rows.pop_front();
        if (out_ch.density_sum !== e.dens) begin
          $display("%0t: density exp %0d got %0d", $time, e.dens, out_ch.density_sum);
          n_errors++;
        end
        if (out_ch.momentum_x !== e.mx) begin
          $display("%0t: momentum_x exp %0d got %0d", $time, e.mx, out_ch.momentum_x);
          n_errors++;
        end
        if (out_ch.momentum_y !== e.my) begin
          $display("%0t: momentum_y exp %0d got %0d", $time, e.my, out_ch.momentum_y);
          n_errors++;
        end
        if (out_ch.momentum_z !== e.mz) begin
          $display("%0t: momentum_z exp %0d got %0d", $time, e.mz, out_ch.momentum_z);
          n_errors++;
        end
        if (out_ch.energy_sum !== e.energy) begin
          $display("%0t: energy exp %0d got %0d", $time, e.energy, out_ch.energy_sum);
          n_errors++;
        end
        if (out_ch.row_index !== e.row) begin
          $display("%0t: row_index exp %0d got %0d", $time, e.row, out_ch.row_index);
          n_errors++;
        end
      end
    end
  end

  // register write over the config channel, mirrored into the shadow copy
  task automatic write_reg(cfg_idx_t idx, int unsigned value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_POINTS_X:     pts_x = value & 9'h1FF;
      CFG_POINTS_Y:     pts_y = value & 9'h1FF;
      CFG_POINTS_Z:     pts_z = value & 9'h1FF;
      CFG_VOLUME_SCALE: vol_scale = value;
      CFG_ROW_COUNT:    rows_cfg = value & 5'h1F;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait until every sample is taken and every expected row has arrived
  task automatic drain();
    wait (pending_pts.size() == 0);
    @(negedge clk);
    while (in_ch.valid || expected_rows.size() != 0) @(negedge clk);
    // the block may still be working on a sample that ends no row
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_vel(bit extreme);
    if (extreme) return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
    return 16'($urandom);
  endfunction

  task automatic queue_pts(int n, int mode);
    grid_pt_t g;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: g.sample = 32'($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
        1: g.sample = $signed(32'($urandom_range(0, 1023))) - 512;
        default: g.sample = 32'($urandom);
      endcase
      if (mode == 1) g.sample = 32'h7FFF_FFFF;
      g.vx = rand_vel(mode == 1 || $urandom_range(0, 7) == 0);
      g.vy = rand_vel(mode == 1 || $urandom_range(0, 7) == 0);
      g.vz = rand_vel(mode == 1 || $urandom_range(0, 7) == 0);
      pending_pts.push_back(g);
    end
  endtask

  task automatic set_grid(int unsigned x, int unsigned y, int unsigned z,
                          int unsigned scale, int unsigned rows);
    write_reg(CFG_POINTS_X, x);
    write_reg(CFG_POINTS_Y, y);
    write_reg(CFG_POINTS_Z, z);
    write_reg(CFG_VOLUME_SCALE, scale);
    write_reg(CFG_ROW_COUNT, rows);
  endtask

  // stimulus
  initial begin
    int unsigned gx, gy, gz;
    grid_pt_t g;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    rst_n = 1'b0;
    n_errors = 0; hold_off = 0;
    pts_x = 3; pts_y = 3; pts_z = 3; vol_scale = 65536; rows_cfg = 1;
    ix = 0; iy = 0; iz = 0; row_ctr = 0;
    for (int k = 0; k < 5; k++) acc[k] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: a 2x2x2 grid with field extremes, then a 3x3x3 at full scale with extremes
    set_grid(0, 1, 2, 65536, 0);
    g = '{32'h7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    pending_pts.push_back(g);
    g = '{32'h8000_0000, 16'sh8000, 16'sh8000, 16'sh8000};
    pending_pts.push_back(g);
    g = '{32'h0000_0001, 16'sh0001, -16'sh0001, 16'sh0000};
    pending_pts.push_back(g);
    g = '{32'hFFFF_FFFF, 16'sh0100, 16'sh0000, -16'sh0100};
    pending_pts.push_back(g);
    queue_pts(4, 0);
    drain();
    set_grid(3, 3, 3, 32'hFFFF_FFFF, 31);
    queue_pts(27, 1);
    drain();
    // shrink the grid mid-row: counters past the end act as end points
    set_grid(4, 4, 4, 0, 3);
    queue_pts(30, 0);
    drain();
    set_grid(2, 2, 2, 65536, 16);
    queue_pts(8 - (30 % 8 == 0 ? 8 : 0), 0);
    drain();

    // long receiver hold-off while the sender keeps offering
    set_grid(2, 2, 2, 65536, 5);
    fork
      queue_pts(80, 0);
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
    join
    drain();

    // random phases; one full row of 256 along z, one partial row above the max
    for (int ph = 0; ph < 12; ph++) begin
      gx = $urandom_range(2, 4); gy = $urandom_range(2, 4); gz = $urandom_range(2, 4);
      if (ph == 5) begin gx = 2; gy = 2; gz = 256; end
      if (ph == 6) begin gx = 2; gy = 2; gz = 300; end
      set_grid(gx, gy, gz, (ph % 3 == 0) ? $urandom : $urandom_range(0, 131072),
               $urandom_range(0, 20));
      queue_pts((ph == 5) ? 1024 : ((ph == 6) ? 100 : gx * gy * gz + 20 * (ph % 2)), 0);
      drain();
    end
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // global limit
  initial begin
    #(8 * 400000);
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
